### rtl/mlp_pkg.sv
// Shared types, codes and the sigmoid table for the perceptron forward-pass block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

    localparam int MaxLayers  = 4;
    localparam int MaxNeurons = 16;
    localparam int ValueBits  = 16;
    localparam int FracBits   = 12;
    localparam int AccBits    = 38;
    localparam int RomSize    = 256;
    localparam int DrainCycles = 4;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_INPUT  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_INPUT_COUNT = 3'd1;
    localparam logic [2:0] REG_NEURONS0    = 3'd2;
    localparam logic [2:0] REG_NEURONS1    = 3'd3;
    localparam logic [2:0] REG_NEURONS2    = 3'd4;
    localparam logic [2:0] REG_NEURONS3    = 3'd5;

    typedef struct packed {
        cmd_t              command;
        logic [1:0]        layer;
        logic [3:0]        neuron;
        logic [3:0]        position;
        logic signed [15:0] value;
        logic              final_req;
    } in_item_t;

    typedef struct packed {
        logic [12:0] activation;
        logic [3:0]  out_neuron;
        logic        end_of_run;
    } out_item_t;

    // Clamped configuration as the sequencer uses it.
    typedef struct packed {
        logic [2:0]      layers;
        logic [4:0]      inputs;
        logic [3:0][4:0] neurons;
    } cfg_t;

    // Sequencer to datapath commands.
    typedef struct packed {
        logic       load;
        logic       issue;
        logic       first;
        logic       last;
        logic [1:0] layer;
        logic [3:0] neuron;
        logic [3:0] pos;
        logic       out_rd;
    } dp_cmd_t;

    // Status seen by the sequencer.
    typedef struct packed {
        logic start;
        logic m_fire;
    } ctrl_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } state_t;

    typedef logic [12:0] sig_rom_t [RomSize];

    function automatic longint unsigned mul_q62(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned m, a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
        m   = 64'hFFFF_FFFF;
        a0  = a & m;
        a1  = a >> 32;
        b0  = b & m;
        b1  = b >> 32;
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = (p00 >> 32) + (p01 & m) + (p10 & m);
        lo  = (mid << 32) | (p00 & m);
        hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    // Restoring division of 64-bit unsigned values, used while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo, rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Evaluated at elaboration only: exp(-1/32) by series, then one
    // restoring division per pair of table entries, mirrored around the midpoint.
    function automatic sig_rom_t build_rom();
        sig_rom_t        rom;
        longint unsigned one, term, q, q2, p, den, r, quo;
        longint unsigned nn;
        one  = 64'd1 << 62;
        term = one;
        q    = one;
        for (int n = 1; n <= 20; n++) begin
            nn   = 64'(n);
            term = div_u64(term, 64'd32 * nn);
            if ((n % 2) == 1) q = q - term;
            else q = q + term;
        end
        q2 = mul_q62(q, q);
        p  = q;
        for (int k = 0; k < RomSize / 2; k++) begin
            den = one + p;
            r   = one;
            quo = 0;
            for (int i = 0; i < 13; i++) begin
                r   = r << 1;
                quo = quo << 1;
                if (r >= den) begin
                    r   = r - den;
                    quo = quo | 64'd1;
                end
            end
            quo = (quo + 64'd1) >> 1;
            rom[RomSize / 2 + k]     = quo[12:0];
            rom[RomSize / 2 - 1 - k] = 13'(64'd4096 - quo);
            p = mul_q62(p, q2);
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_rom();

endpackage
`default_nettype wire

### rtl/mlp_dp.sv
// Datapath: weight, bias and activation memories, one MAC pipeline, saturation
// and sigmoid lookup. Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlp_dp
    import mlp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dp_cmd_t  cmd,
    input  wire in_item_t item,
    output logic [12:0]   act_rd
);

    logic signed [15:0] wmem [1024];
    logic signed [15:0] bmem [64];
    logic signed [15:0] amem [32];

    logic signed [15:0] w_rd_reg, b_rd_reg, a_rd_reg;
    logic               v1_reg, f1_reg, l1_reg;
    logic [3:0]         n1_reg;
    logic               d1_reg;

    logic signed [31:0] prod_reg;
    logic signed [15:0] b2_reg;
    logic               v2_reg, f2_reg, l2_reg;
    logic [3:0]         n2_reg;
    logic               d2_reg;

    logic signed [AccBits-1:0] acc_reg;
    logic               v3_reg, l3_reg;
    logic [3:0]         n3_reg;
    logic               d3_reg;

    logic [4:0]         a_raddr;
    logic signed [15:0] sat;
    logic [7:0]         rom_idx;
    logic [12:0]        sig_val;
    logic               result_we;
    logic signed [AccBits-1:0] acc_base;

    assign a_raddr = cmd.out_rd ? {~cmd.layer[0], cmd.neuron} : {cmd.layer[0], cmd.pos};

    always_ff @(posedge aclk) begin
        if (cmd.load && item.command == CMD_WEIGHT) begin
            wmem[{item.layer, item.neuron, item.position}] <= item.value;
        end
        w_rd_reg <= wmem[{cmd.layer, cmd.neuron, cmd.pos}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && item.command == CMD_BIAS) begin
            bmem[{item.layer, item.neuron}] <= item.value;
        end
        b_rd_reg <= bmem[{cmd.layer, cmd.neuron}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && item.command == CMD_INPUT) begin
            amem[{1'b0, item.position}] <= item.value;
        end else if (result_we) begin
            amem[{d3_reg, n3_reg}] <= signed'({3'b000, sig_val});
        end
        a_rd_reg <= amem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign acc_base = f2_reg ? {{(AccBits-ValueBits-FracBits){b2_reg[15]}}, b2_reg,
                                {FracBits{1'b0}}} : acc_reg;

    always_ff @(posedge aclk) begin
        f1_reg   <= cmd.first;
        l1_reg   <= cmd.last;
        n1_reg   <= cmd.neuron;
        d1_reg   <= ~cmd.layer[0];
        prod_reg <= a_rd_reg * w_rd_reg;
        b2_reg   <= b_rd_reg;
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg & v1_reg;
        n2_reg   <= n1_reg;
        d2_reg   <= d1_reg;
        if (v2_reg) begin
            acc_reg <= acc_base + {{(AccBits-32){prod_reg[31]}}, prod_reg};
        end
        l3_reg <= l2_reg & v2_reg;
        n3_reg <= n2_reg;
        d3_reg <= d2_reg;
    end

    // The sum in Q14.12 is acc[37:12]; it fits 16 bits (Q4.12) when acc[37:27] agree.
    always_comb begin
        if (acc_reg[AccBits-1:27] == {(AccBits-27){acc_reg[27]}}) begin
            sat = acc_reg[27:12];
        end else if (acc_reg[AccBits-1]) begin
            sat = 16'sh8000;
        end else begin
            sat = 16'sh7FFF;
        end
    end

    assign rom_idx   = {~sat[15], sat[14:8]};
    assign sig_val   = SIG_ROM[rom_idx];
    assign result_we = v3_reg & l3_reg;
    assign act_rd    = a_rd_reg[12:0];

endmodule
`default_nettype wire

### rtl/mlp_ctrl.sv
// Sequencer state machine: walks layers, neurons and inputs, then streams the
// last layer's results out. Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlp_ctrl
    import mlp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire ctrl_stat_t stat,
    output logic            s_ready,
    output logic            out_load,
    output logic            out_last,
    output logic [3:0]      out_idx,
    output dp_cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [1:0] layer_reg, layer_next;
    logic [3:0] neuron_reg, neuron_next;
    logic [3:0] pos_reg, pos_next;
    logic [4:0] nin_reg, nin_next;
    logic [1:0] drain_reg, drain_next;

    logic [4:0] cnt_cur;
    logic       last_i, last_j, last_l;

    assign cnt_cur = cfg.neurons[layer_reg];
    assign last_i  = ({1'b0, pos_reg} + 5'd1) == nin_reg;
    assign last_j  = ({1'b0, neuron_reg} + 5'd1) == cnt_cur;
    assign last_l  = ({1'b0, layer_reg} + 3'd1) == cfg.layers;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            layer_reg  <= '0;
            neuron_reg <= '0;
            pos_reg    <= '0;
            nin_reg    <= 5'd1;
            drain_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            layer_reg  <= layer_next;
            neuron_reg <= neuron_next;
            pos_reg    <= pos_next;
            nin_reg    <= nin_next;
            drain_reg  <= drain_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        layer_next  = layer_reg;
        neuron_next = neuron_reg;
        pos_next    = pos_reg;
        nin_next    = nin_reg;
        drain_next  = drain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.start) begin
                    state_next  = ST_ISSUE;
                    layer_next  = '0;
                    neuron_next = '0;
                    pos_next    = '0;
                    nin_next    = cfg.inputs;
                end
            end
            ST_ISSUE: begin
                if (last_i) begin
                    pos_next = '0;
                    if (last_j) begin
                        neuron_next = '0;
                        drain_next  = '0;
                        state_next  = ST_DRAIN;
                    end else begin
                        neuron_next = neuron_reg + 4'd1;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 2'd1;
                // The last result of the layer is written once the pipeline empties.
                if (drain_reg == 2'(DrainCycles - 1)) begin
                    if (last_l) begin
                        state_next = ST_OUT_RD;
                    end else begin
                        layer_next = layer_reg + 2'd1;
                        nin_next   = cnt_cur;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (stat.m_fire) begin
                    if (last_j) begin
                        state_next = ST_IDLE;
                    end else begin
                        neuron_next = neuron_reg + 4'd1;
                        state_next  = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        cmd.layer  = layer_reg;
        cmd.neuron = neuron_reg;
        cmd.pos    = pos_reg;
        cmd.first  = (pos_reg == 4'd0);
        cmd.last   = last_i;
        unique case (state_reg)
            ST_IDLE:     s_ready   = 1'b1;
            ST_ISSUE:    cmd.issue = 1'b1;
            ST_OUT_RD:   cmd.out_rd = 1'b1;
            ST_OUT_WAIT: out_load  = 1'b1;
            default: ;
        endcase
        cmd.load = 1'b0;
    end

    assign out_last = last_j;
    assign out_idx  = neuron_reg;

endmodule
`default_nettype wire

### rtl/mlp_forward_sigmoid.sv
// Top level: configuration registers, handshakes and result register around
// the sequencer (mlp_ctrl) and datapath (mlp_dp). Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
// An input sample with final_req set starts a pass: one shared multiply-accumulate
// unit does one product per cycle over each layer's neurons and inputs, then the
// pipeline empties before the next layer; each result is then read, loaded into the
// output register and held until m_ready takes it. No new item is accepted until
// the last result (end_of_run) has been transferred.
module mlp_forward_sigmoid
    import mlp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [2:0] layer_count_reg;
    logic [4:0] input_count_reg;
    logic [3:0][4:0] neurons_reg;

    logic       cfg_we;
    logic [2:0] cfg_idx;
    cfg_t       cfg;
    ctrl_stat_t stat;
    dp_cmd_t    ctrl_cmd, dp_cmd;
    logic       s_fire, m_fire;
    logic       out_load, out_last;
    logic [3:0] out_idx;
    logic [12:0] act_rd;

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_payload_reg;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= 3'd1;
            input_count_reg <= 5'd16;
            neurons_reg     <= {4{5'd16}};
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_LAYER_COUNT: layer_count_reg <= pwdata[2:0];
                REG_INPUT_COUNT: input_count_reg <= pwdata[4:0];
                REG_NEURONS0:    neurons_reg[0]  <= pwdata[4:0];
                REG_NEURONS1:    neurons_reg[1]  <= pwdata[4:0];
                REG_NEURONS2:    neurons_reg[2]  <= pwdata[4:0];
                REG_NEURONS3:    neurons_reg[3]  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LAYER_COUNT: prdata = {29'd0, layer_count_reg};
            REG_INPUT_COUNT: prdata = {27'd0, input_count_reg};
            REG_NEURONS0:    prdata = {27'd0, neurons_reg[0]};
            REG_NEURONS1:    prdata = {27'd0, neurons_reg[1]};
            REG_NEURONS2:    prdata = {27'd0, neurons_reg[2]};
            REG_NEURONS3:    prdata = {27'd0, neurons_reg[3]};
            default:         prdata = '0;
        endcase
    end

    // Counts of zero run as one; counts above the hardware limits saturate.
    always_comb begin
        if (layer_count_reg == 3'd0) cfg.layers = 3'd1;
        else if (layer_count_reg > 3'(MaxLayers)) cfg.layers = 3'(MaxLayers);
        else cfg.layers = layer_count_reg;
        if (input_count_reg == 5'd0) cfg.inputs = 5'd1;
        else if (input_count_reg > 5'(MaxNeurons)) cfg.inputs = 5'(MaxNeurons);
        else cfg.inputs = input_count_reg;
        for (int k = 0; k < MaxLayers; k++) begin
            if (neurons_reg[k] == 5'd0) cfg.neurons[k] = 5'd1;
            else if (neurons_reg[k] > 5'(MaxNeurons)) cfg.neurons[k] = 5'(MaxNeurons);
            else cfg.neurons[k] = neurons_reg[k];
        end
    end

    assign s_fire     = s_valid & s_ready;
    assign m_fire     = m_valid_reg & m_ready;
    assign stat.start = s_fire & (s_payload.command == CMD_INPUT) & s_payload.final_req;
    assign stat.m_fire = m_fire;

    mlp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .stat     (stat),
        .s_ready  (s_ready),
        .out_load (out_load),
        .out_last (out_last),
        .out_idx  (out_idx),
        .cmd      (ctrl_cmd)
    );

    always_comb begin
        dp_cmd      = ctrl_cmd;
        dp_cmd.load = s_fire;
    end

    mlp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dp_cmd),
        .item    (s_payload),
        .act_rd  (act_rd)
    );

    always_comb begin
        if (out_load) m_valid_next = 1'b1;
        else if (m_fire) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.activation <= act_rd;
            m_payload_reg.out_neuron <= out_idx;
            m_payload_reg.end_of_run <= out_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // No new item is taken while a result is waiting.
    a_ready_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a result is pending");

    // A pass start must leave the idle state.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.command == CMD_INPUT && s_payload.final_req)
        |=> !s_ready)
        else $error("block idle right after a pass start");

    // A result that is not the last of the pass keeps the block busy.
    a_mid_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_payload.end_of_run) |=> !s_ready)
        else $error("block idle before the end of the pass");

    // The last result returns the block to idle.
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.end_of_run) |=> s_ready)
        else $error("block not idle after the end of the pass");

endmodule
`default_nettype wire
